FILE: hw/rtl/tgl_pkg.sv
// shared types, codes and defaults for the tile grid lookup
package tgl_pkg;

   // default table depths, all powers of two
   localparam int unsigned TOP_DEPTH_DEF    = 64;
   localparam int unsigned COARSE_DEPTH_DEF = 256;
   localparam int unsigned LEAF_DEPTH_DEF   = 4096;

   localparam int unsigned SIZE_W      = 13;
   localparam int unsigned COORD_W     = 16;
   localparam int unsigned LEVEL_W     = 3;
   localparam int unsigned INDEX_W     = 12;
   localparam int unsigned CELL_W      = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned NUM_LEVELS  = 5;

   typedef logic [LEVEL_W-1:0]     level_type;
   typedef logic [SIZE_W-1:0]      size_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam level_type LEVEL_0 = 3'd0;
   localparam level_type LEVEL_1 = 3'd1;
   localparam level_type LEVEL_2 = 3'd2;
   localparam level_type LEVEL_3 = 3'd3;
   localparam level_type LEVEL_4 = 3'd4;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   localparam csr_index_type CSR_SIZE_L0 = 3'd0;
   localparam csr_index_type CSR_SIZE_L1 = 3'd1;
   localparam csr_index_type CSR_SIZE_L2 = 3'd2;
   localparam csr_index_type CSR_SIZE_L3 = 3'd3;
   localparam csr_index_type CSR_SIZE_L4 = 3'd4;

   localparam size_type SIZE_RESET_L0 = 13'd1024;
   localparam size_type SIZE_RESET_L1 = 13'd256;
   localparam size_type SIZE_RESET_L2 = 13'd64;
   localparam size_type SIZE_RESET_L3 = 13'd16;
   localparam size_type SIZE_RESET_L4 = 13'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic      write;
      logic      latch;
      logic      kill;
      logic      step;
      level_type step_level;
      logic      capture;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } status_type;

endpackage

FILE: hw/rtl/tgl_ram.sv
// generic single-write, single-read ram with registered read data
module tgl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tgl_ctrl.sv
// controller: issues table writes and sequences the per-level table reads of one lookup
module tgl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  tgl_pkg::level_type    req_level,
   input  tgl_pkg::status_type   status,
   output tgl_pkg::cmd_type      cmd
);
   import tgl_pkg::*;

   state_type state_ff, state_in;
   level_type cur_ff, cur_in;
   level_type tgt_ff, tgt_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= LEVEL_0;
         tgt_ff   <= LEVEL_0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         tgt_ff   <= tgt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      tgt_in         = tgt_ff;
      cmd            = '0;
      req_stall      = (state_ff != ST_IDLE);
      accept         = req_valid && (state_ff == ST_IDLE);
      cmd.step_level = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.latch = 1'b1;
                  tgt_in    = req_level;
                  if (req_level > LEVEL_4) begin
                     // unknown level answers cell 0
                     cmd.kill = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     // walk starts at the coarsest grid the level needs
                     cur_in   = (req_level == LEVEL_4) ? LEVEL_4 : LEVEL_3;
                     state_in = ST_STEP;
                  end
               end
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (cur_ff == tgt_ff) begin
               state_in = ST_FINISH;
            end else begin
               cur_in = cur_ff - 3'd1;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (cur_ff >= tgt_ff && cur_ff <= LEVEL_4))
      else $error("step level below target or beyond top level");

   a_step_descends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && cur_ff != tgt_ff) |=>
         (state_ff == ST_STEP && cur_ff == $past(cur_ff) - 3'd1))
      else $error("level walk skipped a level");

endmodule

FILE: hw/rtl/tgl_datapath.sv
// datapath: grid size registers, coordinate logic, tables and result register
module tgl_datapath #(
   parameter int unsigned TOP_DEPTH    = tgl_pkg::TOP_DEPTH_DEF,
   parameter int unsigned COARSE_DEPTH = tgl_pkg::COARSE_DEPTH_DEF,
   parameter int unsigned LEAF_DEPTH   = tgl_pkg::LEAF_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tgl_pkg::level_type                 req_level,
   input  logic signed [tgl_pkg::COORD_W-1:0] req_column,
   input  logic signed [tgl_pkg::COORD_W-1:0] req_row_coord,
   input  logic [tgl_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [tgl_pkg::CELL_W-1:0]         req_entry_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  tgl_pkg::csr_index_type             csr_index,
   input  tgl_pkg::size_type                  csr_wdata,
   input  tgl_pkg::cmd_type                   cmd,
   output tgl_pkg::status_type                status,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tgl_pkg::CELL_W-1:0]         rsp_cell_res
);
   import tgl_pkg::*;

   localparam int unsigned TOP_AW    = $clog2(TOP_DEPTH);
   localparam int unsigned COARSE_AW = $clog2(COARSE_DEPTH);
   localparam int unsigned LEAF_AW   = $clog2(LEAF_DEPTH);

   size_type              size_ff [NUM_LEVELS];
   logic [COORD_W-1:0]    col_ff;
   logic [COORD_W-1:0]    row_ff;
   level_type             lvl_ff;
   level_type             src_ff;
   logic                  ok_ff;
   logic                  rsp_valid_ff;
   logic [CELL_W-1:0]     cell_ff;

   level_type             diff;
   logic [2:0]            shamt;
   logic [COORD_W-1:0]    sc;
   logic [COORD_W-1:0]    sr;
   size_type              size_sel;
   logic                  in_range;
   logic [CELL_W-1:0]     parent;
   logic [INDEX_W-1:0]    leaf_full;
   logic [TOP_AW-1:0]     top_addr;
   logic [COARSE_AW-1:0]  coarse_addr;
   logic [LEAF_AW-1:0]    leaf_addr;
   logic [NUM_LEVELS-1:0] re;
   logic [NUM_LEVELS-1:0] we;
   logic                  idx_top_ok;
   logic                  idx_coarse_ok;
   logic                  idx_leaf_ok;
   logic [CELL_W-1:0]     top_rd;
   logic [CELL_W-1:0]     coarse_rd;
   logic [CELL_W-1:0]     l2_rd;
   logic [CELL_W-1:0]     l1_rd;
   logic [CELL_W-1:0]     l0_rd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SIZE_RESET_L0;
         size_ff[1] <= SIZE_RESET_L1;
         size_ff[2] <= SIZE_RESET_L2;
         size_ff[3] <= SIZE_RESET_L3;
         size_ff[4] <= SIZE_RESET_L4;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIZE_L0: size_ff[0] <= csr_wdata;
            CSR_SIZE_L1: size_ff[1] <= csr_wdata;
            CSR_SIZE_L2: size_ff[2] <= csr_wdata;
            CSR_SIZE_L3: size_ff[3] <= csr_wdata;
            CSR_SIZE_L4: size_ff[4] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // coordinates at the level being read: coarser levels see col >> 2 per level, level 4 sees col + 2
   always_comb begin
      diff  = cmd.step_level - lvl_ff;
      shamt = {diff[1:0], 1'b0};
      if (cmd.step_level == LEVEL_4) begin
         sc = col_ff + 16'd2;
         sr = row_ff + 16'd2;
      end else begin
         sc = col_ff >> shamt;
         sr = row_ff >> shamt;
      end
      size_sel = size_ff[cmd.step_level];
      in_range = !sc[COORD_W-1] && !sr[COORD_W-1] &&
                 ({2'b00, size_sel} > sc[COORD_W-2:0]) &&
                 ({2'b00, size_sel} > sr[COORD_W-2:0]);
   end

   // parent cell from the previous level's read, 0 when that level was out of range
   always_comb begin
      case (src_ff)
         LEVEL_4: parent = top_rd;
         LEVEL_3: parent = coarse_rd;
         LEVEL_2: parent = l2_rd;
         LEVEL_1: parent = l1_rd;
         default: parent = l0_rd;
      endcase
      if (!ok_ff) begin
         parent = '0;
      end
   end

   assign top_addr    = sc[TOP_AW-1:0] + TOP_AW'(sr << 3);
   assign coarse_addr = sc[COARSE_AW-1:0] + COARSE_AW'(sr << 4);
   assign leaf_full   = {parent, sr[1:0], sc[1:0]};
   assign leaf_addr   = leaf_full[LEAF_AW-1:0];

   assign re[4] = cmd.step && (cmd.step_level == LEVEL_4);
   assign re[3] = cmd.step && (cmd.step_level == LEVEL_3);
   assign re[2] = cmd.step && (cmd.step_level == LEVEL_2);
   assign re[1] = cmd.step && (cmd.step_level == LEVEL_1);
   assign re[0] = cmd.step && (cmd.step_level == LEVEL_0);

   // writes beyond a table's depth are dropped
   assign idx_top_ok    = {1'b0, req_entry_index} < 13'(TOP_DEPTH);
   assign idx_coarse_ok = {1'b0, req_entry_index} < 13'(COARSE_DEPTH);
   assign idx_leaf_ok   = {1'b0, req_entry_index} < 13'(LEAF_DEPTH);

   assign we[4] = cmd.write && (req_level == LEVEL_4) && idx_top_ok;
   assign we[3] = cmd.write && (req_level == LEVEL_3) && idx_coarse_ok;
   assign we[2] = cmd.write && (req_level == LEVEL_2) && idx_leaf_ok;
   assign we[1] = cmd.write && (req_level == LEVEL_1) && idx_leaf_ok;
   assign we[0] = cmd.write && (req_level == LEVEL_0) && idx_leaf_ok;

   tgl_ram #(.WIDTH(CELL_W), .DEPTH(TOP_DEPTH)) u_top (
      .clock   (clock),
      .wr_en   (we[4]),
      .wr_addr (req_entry_index[TOP_AW-1:0]),
      .wr_data (req_entry_data),
      .rd_en   (re[4]),
      .rd_addr (top_addr),
      .rd_data (top_rd)
   );

   tgl_ram #(.WIDTH(CELL_W), .DEPTH(COARSE_DEPTH)) u_coarse (
      .clock   (clock),
      .wr_en   (we[3]),
      .wr_addr (req_entry_index[COARSE_AW-1:0]),
      .wr_data (req_entry_data),
      .rd_en   (re[3]),
      .rd_addr (coarse_addr),
      .rd_data (coarse_rd)
   );

   tgl_ram #(.WIDTH(CELL_W), .DEPTH(LEAF_DEPTH)) u_leaf2 (
      .clock   (clock),
      .wr_en   (we[2]),
      .wr_addr (req_entry_index[LEAF_AW-1:0]),
      .wr_data (req_entry_data),
      .rd_en   (re[2]),
      .rd_addr (leaf_addr),
      .rd_data (l2_rd)
   );

   tgl_ram #(.WIDTH(CELL_W), .DEPTH(LEAF_DEPTH)) u_leaf1 (
      .clock   (clock),
      .wr_en   (we[1]),
      .wr_addr (req_entry_index[LEAF_AW-1:0]),
      .wr_data (req_entry_data),
      .rd_en   (re[1]),
      .rd_addr (leaf_addr),
      .rd_data (l1_rd)
   );

   tgl_ram #(.WIDTH(CELL_W), .DEPTH(LEAF_DEPTH)) u_leaf0 (
      .clock   (clock),
      .wr_en   (we[0]),
      .wr_addr (req_entry_index[LEAF_AW-1:0]),
      .wr_data (req_entry_data),
      .rd_en   (re[0]),
      .rd_addr (leaf_addr),
      .rd_data (l0_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         col_ff <= req_column;
         row_ff <= req_row_coord;
         lvl_ff <= req_level;
      end
      if (cmd.step) begin
         src_ff <= cmd.step_level;
      end
      if (cmd.capture) begin
         cell_ff <= parent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.kill) begin
            ok_ff <= 1'b0;
         end else if (cmd.step) begin
            ok_ff <= in_range;
         end
         if (cmd.capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_res    = cell_ff;

   a_one_read: assert property (@(posedge clock) disable iff (reset)
      $onehot0(re))
      else $error("more than one table read in a cycle");

   a_no_rw_mix: assert property (@(posedge clock) disable iff (reset)
      !((|we) && (|re)))
      else $error("table write during a lookup walk");

   a_step_level: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (cmd.step_level >= lvl_ff))
      else $error("table read finer than the requested level");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.capture)
      else $error("result overwritten while still pending");

endmodule

FILE: hw/rtl/hierarchical_tile_grid_lookup.sv
// top level of the hierarchical tile grid lookup
// write transaction: gives no result; the next transaction is taken the cycle after
// lookup at level L: one table read per level walked (levels 3 down to L for L<=3,
// the top table only for level 4, none for an unknown level), in the order of the
// chained registered table reads; the result is then captured, raising rsp_valid, once
// no earlier result is held by rsp_stall; the next transaction is taken after that
// reset (synchronous) clears control and loads default grid sizes; tables are not cleared
module hierarchical_tile_grid_lookup #(
   parameter int unsigned TOP_DEPTH    = tgl_pkg::TOP_DEPTH_DEF,
   parameter int unsigned COARSE_DEPTH = tgl_pkg::COARSE_DEPTH_DEF,
   parameter int unsigned LEAF_DEPTH   = tgl_pkg::LEAF_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  tgl_pkg::level_type                 req_level,
   input  logic signed [tgl_pkg::COORD_W-1:0] req_column,
   input  logic signed [tgl_pkg::COORD_W-1:0] req_row_coord,
   input  logic [tgl_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [tgl_pkg::CELL_W-1:0]         req_entry_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tgl_pkg::CELL_W-1:0]         rsp_cell_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  tgl_pkg::csr_index_type             csr_index,
   input  tgl_pkg::size_type                  csr_wdata
);
   import tgl_pkg::*;

   cmd_type    cmd;
   status_type status;

   tgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_level (req_level),
      .status    (status),
      .cmd       (cmd)
   );

   tgl_datapath #(
      .TOP_DEPTH    (TOP_DEPTH),
      .COARSE_DEPTH (COARSE_DEPTH),
      .LEAF_DEPTH   (LEAF_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_level       (req_level),
      .req_column      (req_column),
      .req_row_coord   (req_row_coord),
      .req_entry_index (req_entry_index),
      .req_entry_data  (req_entry_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_res    (rsp_cell_res)
   );

endmodule
